@@ hw/rtl/cse_pkg.sv @@
// cse_pkg: shared types, constants and control store for the clock skew estimator.
// Holds the micro-op and condition codes, the control-word ROM and fixed-point helpers.
// No dependencies; imported by every module of the block.
package cse_pkg;

   localparam int unsigned WORD_W     = 32;
   localparam int unsigned RATE_W     = 19;
   localparam int unsigned CNT_W      = 8;
   localparam int unsigned STATUS_W   = 3;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned TDATA_W    = 96;
   localparam int unsigned UPC_W      = 5;

   localparam int unsigned DS_FRAC    = 12;
   localparam int unsigned CK_FRAC    = 31;
   localparam int unsigned INST_SHIFT = 13;
   localparam int unsigned FILT_SHIFT = 30;

   localparam int unsigned DIV_NUM_W  = 50;
   localparam int unsigned DIV_STEPS  = 32;
   localparam int unsigned DIV_CNT_W  = 6;

   localparam logic signed [WORD_W-1:0] SKEW_ONE = 32'sh4000_0000;
   localparam logic signed [WORD_W-1:0] S32_MAX  = 32'sh7FFF_FFFF;
   localparam logic signed [WORD_W-1:0] S32_MIN  = 32'sh8000_0000;
   localparam logic signed [64:0]       INST_ROUND = 65'sd4096;
   localparam logic signed [65:0]       FILT_ROUND = 66'sh2000_0000;

   typedef enum logic [STATUS_W-1:0] {
      ST_OFF     = 3'd0,
      ST_FIRST   = 3'd1,
      ST_SETTLE  = 3'd2,
      ST_RDERR   = 3'd3,
      ST_ZDIV    = 3'd4,
      ST_UPDATED = 3'd5
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TRACK_ENABLE   = 3'd0,
      CSR_SECONDARY_RATE = 3'd1,
      CSR_COEF_NEW       = 3'd2,
      CSR_COEF_OLD       = 3'd3,
      CSR_SETTLE_COUNT   = 3'd4,
      CSR_INITIAL_SKEW   = 3'd5
   } csr_index_type;

   typedef enum logic [4:0] {
      UOP_NOP,
      UOP_DELTA,
      UOP_DIV_DS,
      UOP_FDS,
      UOP_DIV_CK,
      UOP_FCK,
      UOP_MUL_RATIO,
      UOP_INST,
      UOP_MUL_NEW,
      UOP_MUL_OLD,
      UOP_FILT,
      UOP_MINMAX,
      UOP_SET_OFF,
      UOP_FIRST,
      UOP_SET_RDERR,
      UOP_SETTLE,
      UOP_SET_ZDIV,
      UOP_EMIT
   } uop_type;

   typedef enum logic [3:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_NO_REQ,
      COND_TRACK_OFF,
      COND_FIRST,
      COND_RDERR,
      COND_SETTLE,
      COND_ZDIV,
      COND_DIV_BUSY,
      COND_RSP_FREE
   } cond_type;

   typedef logic [UPC_W-1:0] upc_type;

   typedef struct packed {
      uop_type  uop;
      cond_type cond;
      upc_type  target;
   } uword_type;

   typedef struct packed {
      logic req_valid;
      logic track_off;
      logic first;
      logic rderr;
      logic settle;
      logic zdiv;
      logic div_busy;
      logic rsp_free;
   } flags_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] num;
      logic [WORD_W-1:0]    den;
   } div_req_type;

   typedef struct packed {
      logic              busy;
      logic              ovf;
      logic [WORD_W-1:0] quo;
   } div_rsp_type;

   localparam upc_type UPC_IDLE     = 5'd0;
   localparam upc_type UPC_CHK_OFF  = 5'd1;
   localparam upc_type UPC_CHK_1ST  = 5'd2;
   localparam upc_type UPC_CHK_ERR  = 5'd3;
   localparam upc_type UPC_DELTA    = 5'd4;
   localparam upc_type UPC_CHK_ZDIV = 5'd5;
   localparam upc_type UPC_DS_GO    = 5'd6;
   localparam upc_type UPC_DS_WAIT  = 5'd7;
   localparam upc_type UPC_DS_TAKE  = 5'd8;
   localparam upc_type UPC_CK_GO    = 5'd9;
   localparam upc_type UPC_CK_WAIT  = 5'd10;
   localparam upc_type UPC_CK_TAKE  = 5'd11;
   localparam upc_type UPC_MUL_R    = 5'd12;
   localparam upc_type UPC_INST     = 5'd13;
   localparam upc_type UPC_MUL_N    = 5'd14;
   localparam upc_type UPC_MUL_O    = 5'd15;
   localparam upc_type UPC_FILT     = 5'd16;
   localparam upc_type UPC_MINMAX   = 5'd17;
   localparam upc_type UPC_OFF      = 5'd18;
   localparam upc_type UPC_FIRST    = 5'd19;
   localparam upc_type UPC_RDERR    = 5'd20;
   localparam upc_type UPC_SETTLE   = 5'd21;
   localparam upc_type UPC_ZDIV     = 5'd22;
   localparam upc_type UPC_EMIT     = 5'd23;
   localparam upc_type UPC_EMIT_RT  = 5'd24;

   function automatic uword_type make_uword(uop_type u, cond_type c, upc_type t);
      uword_type w;
      w.uop    = u;
      w.cond   = c;
      w.target = t;
      return w;
   endfunction

   function automatic uword_type ucode_rom(upc_type addr);
      uword_type w;
      case (addr)
         UPC_IDLE:     w = make_uword(UOP_NOP,       COND_NO_REQ,    UPC_IDLE);
         UPC_CHK_OFF:  w = make_uword(UOP_NOP,       COND_TRACK_OFF, UPC_OFF);
         UPC_CHK_1ST:  w = make_uword(UOP_NOP,       COND_FIRST,     UPC_FIRST);
         UPC_CHK_ERR:  w = make_uword(UOP_NOP,       COND_RDERR,     UPC_RDERR);
         UPC_DELTA:    w = make_uword(UOP_DELTA,     COND_SETTLE,    UPC_SETTLE);
         UPC_CHK_ZDIV: w = make_uword(UOP_NOP,       COND_ZDIV,      UPC_ZDIV);
         UPC_DS_GO:    w = make_uword(UOP_DIV_DS,    COND_NEVER,     UPC_IDLE);
         UPC_DS_WAIT:  w = make_uword(UOP_NOP,       COND_DIV_BUSY,  UPC_DS_WAIT);
         UPC_DS_TAKE:  w = make_uword(UOP_FDS,       COND_NEVER,     UPC_IDLE);
         UPC_CK_GO:    w = make_uword(UOP_DIV_CK,    COND_NEVER,     UPC_IDLE);
         UPC_CK_WAIT:  w = make_uword(UOP_NOP,       COND_DIV_BUSY,  UPC_CK_WAIT);
         UPC_CK_TAKE:  w = make_uword(UOP_FCK,       COND_NEVER,     UPC_IDLE);
         UPC_MUL_R:    w = make_uword(UOP_MUL_RATIO, COND_NEVER,     UPC_IDLE);
         UPC_INST:     w = make_uword(UOP_INST,      COND_NEVER,     UPC_IDLE);
         UPC_MUL_N:    w = make_uword(UOP_MUL_NEW,   COND_NEVER,     UPC_IDLE);
         UPC_MUL_O:    w = make_uword(UOP_MUL_OLD,   COND_NEVER,     UPC_IDLE);
         UPC_FILT:     w = make_uword(UOP_FILT,      COND_NEVER,     UPC_IDLE);
         UPC_MINMAX:   w = make_uword(UOP_MINMAX,    COND_ALWAYS,    UPC_EMIT);
         UPC_OFF:      w = make_uword(UOP_SET_OFF,   COND_ALWAYS,    UPC_EMIT);
         UPC_FIRST:    w = make_uword(UOP_FIRST,     COND_ALWAYS,    UPC_EMIT);
         UPC_RDERR:    w = make_uword(UOP_SET_RDERR, COND_ALWAYS,    UPC_EMIT);
         UPC_SETTLE:   w = make_uword(UOP_SETTLE,    COND_ALWAYS,    UPC_EMIT);
         UPC_ZDIV:     w = make_uword(UOP_SET_ZDIV,  COND_ALWAYS,    UPC_EMIT);
         UPC_EMIT:     w = make_uword(UOP_EMIT,      COND_RSP_FREE,  UPC_IDLE);
         UPC_EMIT_RT:  w = make_uword(UOP_NOP,       COND_ALWAYS,    UPC_EMIT);
         default:      w = make_uword(UOP_NOP,       COND_ALWAYS,    UPC_IDLE);
      endcase
      return w;
   endfunction

   function automatic logic signed [WORD_W-1:0] sat32(input logic signed [63:0] v);
      logic signed [WORD_W-1:0] r;
      if (v[63:31] == {33{v[63]}}) begin
         r = v[31:0];
      end else if (v[63]) begin
         r = S32_MIN;
      end else begin
         r = S32_MAX;
      end
      return r;
   endfunction

endpackage

@@ hw/rtl/cse_divider.sv @@
// cse_divider: shared restoring divider, one quotient bit per cycle.
// Flags quotients of 2^32 and above as overflow at start and then skips the iterations.
// Depends on cse_pkg.
module cse_divider
   import cse_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic [WORD_W-1:0]    rem_ff, rem_in;
   logic [WORD_W-1:0]    quo_ff, quo_in;
   logic [WORD_W-1:0]    den_ff, den_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 ovf_ff, ovf_in;
   logic [WORD_W:0]      partial;
   logic [WORD_W:0]      trial;
   logic                 fits;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      ovf_in  = ovf_ff;
      partial = {rem_ff, quo_ff[WORD_W-1]};
      trial   = partial - {1'b0, den_ff};
      fits    = partial >= {1'b0, den_ff};
      if (div_req.start) begin
         ovf_in = WORD_W'(div_req.num[DIV_NUM_W-1:WORD_W]) >= div_req.den;
         rem_in = WORD_W'(div_req.num[DIV_NUM_W-1:WORD_W]);
         quo_in = div_req.num[WORD_W-1:0];
         den_in = div_req.den;
         cnt_in = ovf_in ? '0 : DIV_CNT_W'(DIV_STEPS);
      end else if (cnt_ff != '0) begin
         rem_in = fits ? trial[WORD_W-1:0] : partial[WORD_W-1:0];
         quo_in = {quo_ff[WORD_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         ovf_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         ovf_ff <= ovf_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign div_rsp.busy = cnt_ff != '0;
   assign div_rsp.ovf  = ovf_ff;
   assign div_rsp.quo  = quo_ff;

endmodule

@@ hw/rtl/cse_sequencer.sv @@
// cse_sequencer: micro-program counter, control-store fetch and conditional branching.
// Issues one micro-op per cycle to the datapath; depends on cse_pkg.
module cse_sequencer
   import cse_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  flags_type flags,
   output uop_type   uop,
   output logic      idle
);

   upc_type   pc_ff, pc_in;
   uword_type uword;
   logic      taken;

   always_comb begin
      uword = ucode_rom(pc_ff);
      case (uword.cond)
         COND_NEVER:     taken = 1'b0;
         COND_ALWAYS:    taken = 1'b1;
         COND_NO_REQ:    taken = !flags.req_valid;
         COND_TRACK_OFF: taken = flags.track_off;
         COND_FIRST:     taken = flags.first;
         COND_RDERR:     taken = flags.rderr;
         COND_SETTLE:    taken = flags.settle;
         COND_ZDIV:      taken = flags.zdiv;
         COND_DIV_BUSY:  taken = flags.div_busy;
         COND_RSP_FREE:  taken = flags.rsp_free;
         default:        taken = 1'b0;
      endcase
      pc_in = taken ? uword.target : UPC_W'(pc_ff + 1'b1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= UPC_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

   assign uop  = uword.uop;
   assign idle = pc_ff == UPC_IDLE;

endmodule

@@ hw/rtl/cse_datapath.sv @@
// cse_datapath: configuration registers, tracking state, shared multiplier and result register.
// Executes the micro-ops from cse_sequencer and drives the shared cse_divider; depends on cse_pkg.
module cse_datapath
   import cse_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  uop_type                  uop,
   input  logic                     req_valid,
   input  logic                     req_accept,
   input  logic [WORD_W-1:0]        wall_clock,
   input  logic [WORD_W-1:0]        sample_count,
   input  logic [WORD_W-1:0]        wall_clock_rate,
   input  logic                     read_error,
   input  logic                     csr_wen,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [WORD_W-1:0]        csr_wdata,
   input  div_rsp_type              div_rsp,
   output div_req_type              div_req,
   output flags_type                flags,
   input  logic                     rsp_tready,
   output logic                     rsp_tvalid,
   output logic signed [WORD_W-1:0] filtered_skew,
   output logic signed [WORD_W-1:0] lowest_skew,
   output logic signed [WORD_W-1:0] highest_skew,
   output logic [STATUS_W-1:0]      status
);

   logic                     track_en_ff, track_en_in;
   logic [RATE_W-1:0]        sec_rate_ff, sec_rate_in;
   logic signed [WORD_W-1:0] coef_new_ff, coef_new_in;
   logic signed [WORD_W-1:0] coef_old_ff, coef_old_in;
   logic [CNT_W-1:0]         settle_ff, settle_in;

   logic [WORD_W-1:0]        wc_ff, wc_in;
   logic [WORD_W-1:0]        sc_ff, sc_in;
   logic [WORD_W-1:0]        rate_ff, rate_in;
   logic                     rderr_ff, rderr_in;

   logic [CNT_W-1:0]         event_cnt_ff, event_cnt_in;
   logic [WORD_W-1:0]        last_wc_ff, last_wc_in;
   logic [WORD_W-1:0]        last_sc_ff, last_sc_in;
   logic signed [WORD_W-1:0] skew_now_ff, skew_now_in;
   logic signed [WORD_W-1:0] skew_low_ff, skew_low_in;
   logic signed [WORD_W-1:0] skew_high_ff, skew_high_in;

   logic signed [WORD_W-1:0] dts_ff, dts_in;
   logic signed [WORD_W-1:0] dsm_ff, dsm_in;
   logic signed [WORD_W-1:0] fds_ff, fds_in;
   logic signed [WORD_W-1:0] fck_ff, fck_in;
   logic signed [WORD_W-1:0] inst_ff, inst_in;
   logic signed [63:0]       prod_ff, prod_in;
   logic signed [63:0]       acc_ff, acc_in;
   status_type               status_ff, status_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [WORD_W-1:0] rsp_now_ff, rsp_now_in;
   logic signed [WORD_W-1:0] rsp_low_ff, rsp_low_in;
   logic signed [WORD_W-1:0] rsp_high_ff, rsp_high_in;
   status_type               rsp_status_ff, rsp_status_in;

   logic signed [WORD_W-1:0] mul_a;
   logic signed [WORD_W-1:0] mul_b;
   logic signed [63:0]       mul_p;
   logic [WORD_W-1:0]        dts_abs;
   logic [WORD_W-1:0]        dsm_abs;
   logic signed [64:0]       inst_sum;
   logic signed [64:0]       inst_sh;
   logic signed [65:0]       filt_sum;
   logic signed [65:0]       filt_sh;
   logic                     rsp_free;
   logic                     ds_neg;
   logic signed [WORD_W-1:0] load_skew;

   assign dts_abs  = dts_ff[WORD_W-1] ? WORD_W'(-dts_ff) : dts_ff;
   assign dsm_abs  = dsm_ff[WORD_W-1] ? WORD_W'(-dsm_ff) : dsm_ff;
   assign ds_neg   = dts_ff[WORD_W-1] ^ dsm_ff[WORD_W-1];
   assign rsp_free = !rsp_valid_ff || rsp_tready;

   assign inst_sum = 65'(prod_ff) + INST_ROUND;
   assign inst_sh  = inst_sum >>> INST_SHIFT;
   assign filt_sum = 66'(acc_ff) + 66'(prod_ff) + FILT_ROUND;
   assign filt_sh  = filt_sum >>> FILT_SHIFT;
   assign load_skew = (csr_wdata == '0) ? SKEW_ONE : csr_wdata;

   always_comb begin
      case (uop)
         UOP_MUL_RATIO: begin
            mul_a = fds_ff;
            mul_b = fck_ff;
         end
         UOP_MUL_NEW: begin
            mul_a = coef_new_ff;
            mul_b = inst_ff;
         end
         default: begin
            mul_a = coef_old_ff;
            mul_b = skew_now_ff;
         end
      endcase
      mul_p = 64'(mul_a) * 64'(mul_b);
   end

   always_comb begin
      div_req.start = (uop == UOP_DIV_DS) || (uop == UOP_DIV_CK);
      if (uop == UOP_DIV_CK) begin
         div_req.num = {sec_rate_ff, {CK_FRAC{1'b0}}};
         div_req.den = rate_ff;
      end else begin
         div_req.num = {{(DIV_NUM_W - WORD_W - DS_FRAC){1'b0}}, dts_abs, {DS_FRAC{1'b0}}};
         div_req.den = dsm_abs;
      end
   end

   always_comb begin
      track_en_in   = track_en_ff;
      sec_rate_in   = sec_rate_ff;
      coef_new_in   = coef_new_ff;
      coef_old_in   = coef_old_ff;
      settle_in     = settle_ff;
      wc_in         = wc_ff;
      sc_in         = sc_ff;
      rate_in       = rate_ff;
      rderr_in      = rderr_ff;
      event_cnt_in  = event_cnt_ff;
      last_wc_in    = last_wc_ff;
      last_sc_in    = last_sc_ff;
      skew_now_in   = skew_now_ff;
      skew_low_in   = skew_low_ff;
      skew_high_in  = skew_high_ff;
      dts_in        = dts_ff;
      dsm_in        = dsm_ff;
      fds_in        = fds_ff;
      fck_in        = fck_ff;
      inst_in       = inst_ff;
      prod_in       = prod_ff;
      acc_in        = acc_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_now_in    = rsp_now_ff;
      rsp_low_in    = rsp_low_ff;
      rsp_high_in   = rsp_high_ff;
      rsp_status_in = rsp_status_ff;

      if (req_accept) begin
         wc_in    = wall_clock;
         sc_in    = sample_count;
         rate_in  = wall_clock_rate;
         rderr_in = read_error;
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (uop)
         UOP_DELTA: begin
            dts_in     = wc_ff - last_wc_ff;
            dsm_in     = sc_ff - last_sc_ff;
            last_wc_in = wc_ff;
            last_sc_in = sc_ff;
         end
         UOP_FDS: begin
            if (!ds_neg) begin
               fds_in = (div_rsp.ovf || div_rsp.quo[WORD_W-1]) ? S32_MAX : div_rsp.quo;
            end else if (div_rsp.ovf ||
                         (div_rsp.quo[WORD_W-1] && (div_rsp.quo[WORD_W-2:0] != '0))) begin
               fds_in = S32_MIN;
            end else begin
               fds_in = WORD_W'(-div_rsp.quo);
            end
         end
         UOP_FCK: begin
            fck_in = (div_rsp.ovf || div_rsp.quo[WORD_W-1]) ? S32_MAX : div_rsp.quo;
         end
         UOP_MUL_RATIO, UOP_MUL_NEW: begin
            prod_in = mul_p;
         end
         UOP_MUL_OLD: begin
            acc_in  = prod_ff;
            prod_in = mul_p;
         end
         UOP_INST: begin
            inst_in = sat32(inst_sh[63:0]);
         end
         UOP_FILT: begin
            skew_now_in = sat32(filt_sh[63:0]);
            status_in   = ST_UPDATED;
         end
         UOP_MINMAX: begin
            if (skew_now_ff < skew_low_ff) begin
               skew_low_in = skew_now_ff;
            end
            if (skew_now_ff > skew_high_ff) begin
               skew_high_in = skew_now_ff;
            end
         end
         UOP_SET_OFF: begin
            status_in = ST_OFF;
         end
         UOP_FIRST: begin
            event_cnt_in = CNT_W'(1);
            status_in    = ST_FIRST;
         end
         UOP_SET_RDERR: begin
            status_in = ST_RDERR;
         end
         UOP_SETTLE: begin
            event_cnt_in = event_cnt_ff + 1'b1;
            status_in    = ST_SETTLE;
         end
         UOP_SET_ZDIV: begin
            status_in = ST_ZDIV;
         end
         UOP_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_now_in    = skew_now_ff;
               rsp_low_in    = skew_low_ff;
               rsp_high_in   = skew_high_ff;
               rsp_status_in = status_ff;
            end
         end
         default: begin
         end
      endcase

      if (csr_wen) begin
         case (csr_index_type'(csr_index))
            CSR_TRACK_ENABLE: begin
               track_en_in  = csr_wdata[0];
               event_cnt_in = '0;
            end
            CSR_SECONDARY_RATE: sec_rate_in = csr_wdata[RATE_W-1:0];
            CSR_COEF_NEW:       coef_new_in = csr_wdata;
            CSR_COEF_OLD:       coef_old_in = csr_wdata;
            CSR_SETTLE_COUNT:   settle_in   = csr_wdata[CNT_W-1:0];
            CSR_INITIAL_SKEW: begin
               skew_now_in  = load_skew;
               skew_low_in  = load_skew;
               skew_high_in = load_skew;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         track_en_ff   <= 1'b0;
         sec_rate_ff   <= RATE_W'(48000);
         coef_new_ff   <= 32'sd107374182;
         coef_old_ff   <= 32'sd966367642;
         settle_ff     <= CNT_W'(10);
         event_cnt_ff  <= '0;
         last_wc_ff    <= '0;
         last_sc_ff    <= '0;
         skew_now_ff   <= SKEW_ONE;
         skew_low_ff   <= SKEW_ONE;
         skew_high_ff  <= SKEW_ONE;
         status_ff     <= ST_OFF;
         rsp_valid_ff  <= 1'b0;
      end else begin
         track_en_ff   <= track_en_in;
         sec_rate_ff   <= sec_rate_in;
         coef_new_ff   <= coef_new_in;
         coef_old_ff   <= coef_old_in;
         settle_ff     <= settle_in;
         event_cnt_ff  <= event_cnt_in;
         last_wc_ff    <= last_wc_in;
         last_sc_ff    <= last_sc_in;
         skew_now_ff   <= skew_now_in;
         skew_low_ff   <= skew_low_in;
         skew_high_ff  <= skew_high_in;
         status_ff     <= status_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      wc_ff         <= wc_in;
      sc_ff         <= sc_in;
      rate_ff       <= rate_in;
      rderr_ff      <= rderr_in;
      dts_ff        <= dts_in;
      dsm_ff        <= dsm_in;
      fds_ff        <= fds_in;
      fck_ff        <= fck_in;
      inst_ff       <= inst_in;
      prod_ff       <= prod_in;
      acc_ff        <= acc_in;
      rsp_now_ff    <= rsp_now_in;
      rsp_low_ff    <= rsp_low_in;
      rsp_high_ff   <= rsp_high_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign flags.req_valid = req_valid;
   assign flags.track_off = !track_en_ff;
   assign flags.first     = event_cnt_ff == '0;
   assign flags.rderr     = rderr_ff;
   assign flags.settle    = event_cnt_ff < settle_ff;
   assign flags.zdiv      = (dsm_ff == '0) || (rate_ff == '0);
   assign flags.div_busy  = div_rsp.busy;
   assign flags.rsp_free  = rsp_free;

   assign rsp_tvalid    = rsp_valid_ff;
   assign filtered_skew = rsp_now_ff;
   assign lowest_skew   = rsp_low_ff;
   assign highest_skew  = rsp_high_ff;
   assign status        = rsp_status_ff;

endmodule

@@ hw/rtl/clock_skew_estimator.sv @@
// clock_skew_estimator: top level of the first-order clock skew estimator.
// Ties together cse_sequencer, cse_datapath and cse_divider; depends on cse_pkg.
//
//   channel  direction  handshake            payload
//   req      in         req_tvalid/tready    tdata: wall_clock, sample_count, wall_clock_rate
//                                            tuser: read_error
//   rsp      out        rsp_tvalid/tready    tdata: filtered, lowest, highest skew
//                                            tuser: status
//   csr      in         csr_wen              csr_index, csr_wdata (write only)
//
// An event that updates the skew holds req_tready low after its transfer until its result
// is issued, through two 32-step divisions on the one shared divider; an overflowing
// quotient skips its 32 steps. Events that end off, first, read error, settling or zero
// divisor skip both divisions. A blocked result is retried until the output register frees.
// Reset is synchronous; it loads the register defaults and a skew of 1.0.
// A result waits in the output register while rsp_tready is low; the next event is
// taken meanwhile and its result is held back until the register frees.
module clock_skew_estimator
   import cse_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [TDATA_W-1:0]   req_tdata,   // wall_clock, sample_count, wall_clock_rate
   input  logic                 req_tuser,   // read_error
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [TDATA_W-1:0]   rsp_tdata,   // filtered_skew, lowest_skew, highest_skew
   output logic [STATUS_W-1:0]  rsp_tuser,   // status
   input  logic                 csr_wen,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [WORD_W-1:0]    csr_wdata
);

   uop_type                  uop;
   flags_type                flags;
   div_req_type              div_req;
   div_rsp_type              div_rsp;
   logic                     idle;
   logic                     req_accept;
   logic signed [WORD_W-1:0] filtered_skew;
   logic signed [WORD_W-1:0] lowest_skew;
   logic signed [WORD_W-1:0] highest_skew;

   assign req_tready = idle;
   assign req_accept = req_tvalid && idle;

   cse_sequencer u_sequencer (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .uop   (uop),
      .idle  (idle)
   );

   cse_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   cse_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .uop             (uop),
      .req_valid       (req_tvalid),
      .req_accept      (req_accept),
      .wall_clock      (req_tdata[31:0]),
      .sample_count    (req_tdata[63:32]),
      .wall_clock_rate (req_tdata[95:64]),
      .read_error      (req_tuser),
      .csr_wen         (csr_wen),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .div_rsp         (div_rsp),
      .div_req         (div_req),
      .flags           (flags),
      .rsp_tready      (rsp_tready),
      .rsp_tvalid      (rsp_tvalid),
      .filtered_skew   (filtered_skew),
      .lowest_skew     (lowest_skew),
      .highest_skew    (highest_skew),
      .status          (rsp_tuser)
   );

   assign rsp_tdata = {highest_skew, lowest_skew, filtered_skew};

endmodule

@@ hw/rtl/cse_checker.sv @@
// cse_checker: port-level assertions for clock_skew_estimator, bound to the top level.
// Depends on cse_pkg and the top-level port names.
module cse_checker
   import cse_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_tvalid,
   input logic                req_tready,
   input logic                rsp_tvalid,
   input logic                rsp_tready,
   input logic [TDATA_W-1:0]  rsp_tdata,
   input logic [STATUS_W-1:0] rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   a_reset_state: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("reset did not clear result and open input");

   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken while an event is in progress");

   a_skew_bounds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata[63:32]) <= $signed(rsp_tdata[31:0])) &&
                     ($signed(rsp_tdata[31:0]) <= $signed(rsp_tdata[95:64])))
      else $error("filtered skew outside lowest/highest");

endmodule

bind clock_skew_estimator cse_checker u_cse_checker (.*);

@@ dv/tb_clock_skew_estimator.sv @@
`timescale 1ns / 1ps
// tb_clock_skew_estimator: self-checking bench for the clock skew estimator.
// Streams timestamp events and register writes, predicts every report in place and checks it.
// Depends on cse_pkg and the clock_skew_estimator RTL.
module tb_clock_skew_estimator;
   import cse_pkg::*;

   localparam int unsigned IDLE_MAX     = 14;
   localparam int unsigned SETTLE_GAP   = 8;
   localparam int unsigned TAIL_CYCLES  = 200;
   localparam int unsigned STALL_LIMIT  = 4000;
   localparam int unsigned EVENT_TARGET = 1150;
   localparam int unsigned REPORT_MAX   = 10;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_A = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_B = 3'd7;

   typedef enum logic [1:0] {
      STAMP_EVENT,
      STAMP_WRITE,
      STAMP_DRAIN
   } stamp_kind_type;

   typedef struct packed {
      stamp_kind_type       kind;
      logic [31:0]          wall_clock;
      logic [31:0]          sample_count;
      logic [31:0]          wall_hz;
      logic                 read_error;
      logic [CSR_IDX_W-1:0] reg_index;
      logic [WORD_W-1:0]    reg_value;
   } stamp_entry_type;

   typedef struct packed {
      logic [31:0] filtered;
      logic [31:0] lowest;
      logic [31:0] highest;
      status_type  status;
   } skew_report_type;

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [TDATA_W-1:0]   req_tdata  = '0;
   logic                 req_tuser  = 1'b0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [TDATA_W-1:0]   rsp_tdata;
   logic [STATUS_W-1:0]  rsp_tuser;
   logic                 csr_wen    = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index  = '0;
   logic [WORD_W-1:0]    csr_wdata  = '0;

   stamp_entry_type pending_stamps[$];
   skew_report_type awaited_reports[$];

   // tracker state as the block should hold it
   logic               trk_on;
   logic [18:0]        trk_rate;
   logic signed [31:0] trk_coef_new;
   logic signed [31:0] trk_coef_old;
   logic [7:0]         trk_settle;
   logic [7:0]         trk_events;
   logic [31:0]        trk_last_wc;
   logic [31:0]        trk_last_sc;
   logic signed [31:0] trk_skew;
   logic signed [31:0] trk_low;
   logic signed [31:0] trk_high;

   // what the stimulus planner believes is configured
   logic        plan_track  = 1'b0;
   int unsigned plan_rate   = 48000;
   int unsigned plan_settle = 10;
   int unsigned events_planned = 0;

   int unsigned     mismatches = 0;
   int unsigned     leftovers = 0;
   int unsigned     writes_done = 0;
   int unsigned     status_hits[8];
   int unsigned     tx_gap = 0;
   int unsigned     rx_wait = 0;
   int unsigned     quiet = 0;
   int unsigned     idle_run = 0;
   logic            tx_calm = 1'b0;
   logic            rx_calm = 1'b0;
   logic            valid_next;
   logic            wen_next;
   stamp_entry_type head;
   skew_report_type want;
   skew_report_type got;

   clock_skew_estimator i_dut (.*);

   always #1 clock = ~clock;

   function automatic logic signed [31:0] clamp_s32(input logic signed [65:0] v);
      if (v > S32_MAX) return S32_MAX;
      if (v < S32_MIN) return S32_MIN;
      return v[31:0];
   endfunction

   function automatic void load_skew(input logic signed [31:0] v);
      trk_skew = (v == 0) ? SKEW_ONE : v;
      trk_low  = trk_skew;
      trk_high = trk_skew;
   endfunction

   function automatic void reset_tracker();
      trk_on       = 1'b0;
      trk_rate     = 19'd48000;
      trk_coef_new = 32'sd107374182;
      trk_coef_old = 32'sd966367642;
      trk_settle   = 8'd10;
      trk_events   = '0;
      trk_last_wc  = '0;
      trk_last_sc  = '0;
      load_skew(SKEW_ONE);
   endfunction

   function automatic void write_tracker(input logic [CSR_IDX_W-1:0] idx,
                                         input logic [WORD_W-1:0] val);
      case (idx)
         CSR_TRACK_ENABLE: begin
            trk_on     = val[0];
            trk_events = '0;
         end
         CSR_SECONDARY_RATE: trk_rate = val[18:0];
         CSR_COEF_NEW:       trk_coef_new = val;
         CSR_COEF_OLD:       trk_coef_old = val;
         CSR_SETTLE_COUNT:   trk_settle = val[7:0];
         CSR_INITIAL_SKEW:   load_skew(val);
         default: ;
      endcase
   endfunction

   function automatic skew_report_type estimate_skew(input logic [31:0] wc,
                                                    input logic [31:0] sc,
                                                    input logic [31:0] hz, input logic err);
      skew_report_type    r;
      logic signed [31:0] d_ts, d_sm, ratio_ds, ratio_ck, inst;
      logic signed [63:0] num, den, prod, rnd, p1, p2;
      logic signed [65:0] acc;
      logic [63:0]        ck_num, ck_q;
      if (!trk_on) begin
         r.status = ST_OFF;
      end else if (trk_events == 0) begin
         trk_events = 8'd1;
         r.status   = ST_FIRST;
      end else if (err) begin
         r.status = ST_RDERR;
      end else begin
         d_ts        = wc - trk_last_wc;
         d_sm        = sc - trk_last_sc;
         trk_last_wc = wc;
         trk_last_sc = sc;
         if (trk_events < trk_settle) begin
            trk_events = trk_events + 8'd1;
            r.status   = ST_SETTLE;
         end else if (d_sm == 0 || hz == 0) begin
            r.status = ST_ZDIV;
         end else begin
            num      = d_ts;
            num      = num * 64'sd4096;
            den      = d_sm;
            ratio_ds = clamp_s32(num / den);
            ck_num   = {45'd0, trk_rate} << 31;
            ck_q     = ck_num / {32'd0, hz};
            ratio_ck = (ck_q > 64'h7FFF_FFFF) ? S32_MAX : ck_q[31:0];
            prod     = ratio_ds * ratio_ck;
            rnd      = (prod >>> 12) + 64'sd1;
            inst     = clamp_s32(rnd >>> 1);
            p1       = trk_coef_new * inst;
            p2       = trk_coef_old * trk_skew;
            acc      = p1 + p2;
            acc      = ((acc >>> 29) + 66'sd1) >>> 1;
            trk_skew = clamp_s32(acc);
            if (trk_skew < trk_low) trk_low = trk_skew;
            if (trk_skew > trk_high) trk_high = trk_skew;
            r.status = ST_UPDATED;
         end
      end
      r.filtered = trk_skew;
      r.lowest   = trk_low;
      r.highest  = trk_high;
      return r;
   endfunction

   task automatic add_event(input logic [31:0] wc, input logic [31:0] sc,
                            input logic [31:0] hz, input logic err);
      stamp_entry_type e;
      e              = '0;
      e.kind         = STAMP_EVENT;
      e.wall_clock   = wc;
      e.sample_count = sc;
      e.wall_hz      = hz;
      e.read_error   = err;
      pending_stamps.push_back(e);
      if (plan_track) events_planned++;
   endtask

   task automatic add_write(input logic [CSR_IDX_W-1:0] idx, input logic [WORD_W-1:0] val);
      stamp_entry_type e;
      e           = '0;
      e.kind      = STAMP_WRITE;
      e.reg_index = idx;
      e.reg_value = val;
      pending_stamps.push_back(e);
      case (idx)
         CSR_TRACK_ENABLE:   plan_track = val[0];
         CSR_SECONDARY_RATE: plan_rate = 32'(val[18:0]);
         CSR_SETTLE_COUNT:   plan_settle = 32'(val[7:0]);
         default: ;
      endcase
   endtask

   task automatic add_drain();
      stamp_entry_type e;
      e      = '0;
      e.kind = STAMP_DRAIN;
      pending_stamps.push_back(e);
   endtask

   function automatic logic [31:0] extreme_word();
      case ($urandom_range(0, 3))
         0:       return S32_MIN;
         1:       return S32_MAX;
         2:       return 32'h0;
         default: return SKEW_ONE;
      endcase
   endfunction

   task automatic build_directed();
      // tracking off: reports echo the reset skew
      add_event('1, '1, '1, 1'b1);
      add_event('0, '0, '0, 1'b0);
      add_write(CSR_TRACK_ENABLE, 32'h1);
      add_write(CSR_SETTLE_COUNT, 32'h0);
      add_write(CSR_SECONDARY_RATE, 32'd384000);
      add_write(CSR_COEF_NEW, SKEW_ONE);
      add_write(CSR_COEF_OLD, 32'h0);
      add_event(32'd1000, 32'd100, 32'd24_000_000, 1'b0);
      add_event(32'd2000, 32'd200, 32'd24_000_000, 1'b1);
      add_event(32'd25000, 32'd148, 32'd24_000_000, 1'b0);
      add_event(32'd50000, 32'd148, 32'd24_000_000, 1'b0);
      add_event(32'd75000, 32'd196, 32'd0, 1'b0);
      add_event(32'hFFFF_F000, 32'd244, 32'd24_000_000, 1'b0);
      add_event(32'h0000_2000, 32'd292, 32'd24_000_000, 1'b0);
      add_event(32'h7FFF_0000, 32'd293, 32'd24_000_000, 1'b0);
      add_event(32'h7FFF_5DC0, 32'd341, 32'd1, 1'b0);
      add_event(32'h7FFF_BB80, 32'd389, 32'hFFFF_FFFF, 1'b0);
      add_drain();
      add_write(CSR_COEF_NEW, S32_MIN);
      add_write(CSR_COEF_OLD, S32_MAX);
      add_write(CSR_INITIAL_SKEW, S32_MAX);
      add_write(CSR_SECONDARY_RATE, 32'd1);
      add_event(32'h8000_1000, 32'd300, 32'd19_200_000, 1'b0);
      add_event(32'h8000_6000, 32'd200, 32'd19_200_000, 1'b0);
      add_write(CSR_INITIAL_SKEW, 32'h0);
      add_event(32'h8001_0000, 32'd250, 32'd19_200_000, 1'b0);
      add_write(CSR_INITIAL_SKEW, S32_MIN);
      add_write(CSR_SPARE_A, '1);
      add_write(CSR_SPARE_B, 32'h1234_5678);
      add_write(CSR_SETTLE_COUNT, 32'd3);
      add_write(CSR_TRACK_ENABLE, 32'h1);
      add_event(32'd0, 32'd0, 32'd24_000_000, 1'b0);
      add_event(32'd24000, 32'd48, 32'd24_000_000, 1'b0);
      add_event(32'd48000, 32'd96, 32'd24_000_000, 1'b0);
      add_event(32'd72000, 32'd144, 32'd24_000_000, 1'b0);
      add_write(CSR_SETTLE_COUNT, 32'd255);
      add_write(CSR_TRACK_ENABLE, 32'h0);
      add_event(32'd96000, 32'd192, 32'd24_000_000, 1'b0);
   endtask

   task automatic build_phase();
      int unsigned n, hz, tick, span, sstep, roll;
      logic [31:0] wc, sc, cn, junk;
      logic [18:0] srate;
      junk = $urandom();
      if (plan_track && $urandom_range(0, 9) == 0) begin
         add_write(CSR_TRACK_ENABLE, {junk[31:1], 1'b0});
         n = $urandom_range(2, 6);
         for (int i = 0; i < n; i++)
            add_event($urandom(), $urandom(), $urandom(), 1'($urandom()));
         return;
      end
      if ($urandom_range(0, 1) == 0) begin
         case ($urandom_range(0, 7))
            0:       srate = 19'd8000;
            1:       srate = 19'd44100;
            2:       srate = 19'd48000;
            3:       srate = 19'd96000;
            4:       srate = 19'd192000;
            5:       srate = 19'd384000;
            6:       srate = 19'd1;
            default: srate = 19'($urandom_range(1, 19'h7FFFF));
         endcase
         add_write(CSR_SECONDARY_RATE, {junk[31:19], srate});
      end
      if ($urandom_range(0, 1) == 0) begin
         roll = $urandom_range(0, 9);
         if (roll < 6) begin
            cn = $urandom_range(1 << 20, 1 << 30);
            add_write(CSR_COEF_NEW, cn);
            add_write(CSR_COEF_OLD, SKEW_ONE - cn);
         end else if (roll < 8) begin
            add_write(CSR_COEF_NEW, $urandom());
            add_write(CSR_COEF_OLD, $urandom());
         end else begin
            add_write(CSR_COEF_NEW, extreme_word());
            add_write(CSR_COEF_OLD, extreme_word());
         end
      end
      if ($urandom_range(0, 2) == 0) begin
         roll = $urandom_range(0, 19);
         if (roll == 0) add_write(CSR_SETTLE_COUNT, {junk[31:8], 8'd255});
         else if (roll == 1) add_write(CSR_SETTLE_COUNT, {junk[31:8], 8'd0});
         else add_write(CSR_SETTLE_COUNT, {junk[31:8], 8'($urandom_range(1, 12))});
      end
      if ($urandom_range(0, 3) == 0)
         add_write(CSR_INITIAL_SKEW, $urandom_range(0, 1) ? $urandom() : extreme_word());
      if ($urandom_range(0, 9) == 0) add_write($urandom_range(0, 1) ? CSR_SPARE_A : CSR_SPARE_B,
                                                $urandom());
      if (!plan_track || $urandom_range(0, 3) != 0) add_write(CSR_TRACK_ENABLE, {junk[31:1], 1'b1});

      case ($urandom_range(0, 4))
         0:       hz = 19_200_000;
         1:       hz = 24_000_000;
         2:       hz = 38_400_000;
         3:       hz = 1_000_000;
         default: hz = $urandom_range(100_000, 32'hFFFF_FFFF);
      endcase
      tick  = hz / 1000;
      span  = tick / 200 + 1;
      sstep = (plan_rate < 1000) ? 1 : plan_rate / 1000;
      wc    = $urandom();
      sc    = $urandom();
      n     = (plan_settle > 20) ? plan_settle + 40 : $urandom_range(15, 70);
      roll  = $urandom_range(0, 3);
      for (int i = 0; i < n; i++) begin
         if (roll == 0 && i == n / 2) add_drain();
         wc = wc + tick - span + $urandom_range(0, 2 * span);
         case ($urandom_range(0, 99)) inside
            [0:77]: begin
               sc = sc + sstep + (($urandom_range(0, 7) == 0) ? 1 : 0);
               add_event(wc, sc, hz, 1'b0);
            end
            [78:83]: begin
               sc = sc + sstep;
               add_event(wc, sc, hz, 1'b1);
            end
            [84:87]: add_event(wc, sc, hz, 1'b0);
            [88:90]: begin
               sc = sc + sstep;
               add_event(wc, sc, 32'd0, 1'b0);
            end
            default: add_event($urandom(), $urandom(), $urandom(), 1'($urandom_range(0, 1)));
         endcase
      end
   endtask

   // sender: events from the pending queue, register writes only once the block is idle
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         csr_wen    <= 1'b0;
         tx_gap = 0;
         quiet  = 0;
      end else begin
         valid_next = req_tvalid;
         wen_next   = 1'b0;
         if (req_tvalid && req_tready) begin
            head = pending_stamps.pop_front();
            awaited_reports.push_back(estimate_skew(head.wall_clock, head.sample_count,
                                                    head.wall_hz, head.read_error));
            valid_next = 1'b0;
            tx_gap = tx_calm ? 0 : $urandom_range(0, IDLE_MAX);
            if ($urandom_range(0, 31) == 0) tx_calm = ~tx_calm;
         end
         if (!valid_next && pending_stamps.size() != 0) begin
            if (tx_gap != 0) begin
               tx_gap--;
            end else begin
               head = pending_stamps[0];
               if (head.kind == STAMP_EVENT) begin
                  valid_next = 1'b1;
                  req_tdata <= {head.wall_hz, head.sample_count, head.wall_clock};
                  req_tuser <= head.read_error;
               end else if (quiet >= SETTLE_GAP) begin
                  if (head.kind == STAMP_WRITE) begin
                     wen_next = 1'b1;
                     csr_index <= head.reg_index;
                     csr_wdata <= head.reg_value;
                     write_tracker(head.reg_index, head.reg_value);
                     writes_done++;
                  end
                  head = pending_stamps.pop_front();
               end
            end
         end
         quiet = (awaited_reports.size() == 0 && !req_tvalid && !valid_next) ? quiet + 1 : 0;
         req_tvalid <= valid_next;
         csr_wen    <= wen_next;
      end
   end

   task automatic note_mismatch(input string what, input skew_report_type exp_r,
                                input skew_report_type act_r);
      mismatches++;
      if (mismatches <= REPORT_MAX)
         $display("%0t %s: expected skew %h low %h high %h status %0d, got %h %h %h %0d",
                  $time, what, exp_r.filtered, exp_r.lowest, exp_r.highest, exp_r.status,
                  act_r.filtered, act_r.lowest, act_r.highest, act_r.status);
   endtask

   // receiver: check each transfer against the oldest awaited report
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rx_wait = 0;
      end else if (rsp_tvalid && rsp_tready) begin
         got.filtered = rsp_tdata[31:0];
         got.lowest   = rsp_tdata[63:32];
         got.highest  = rsp_tdata[95:64];
         got.status   = status_type'(rsp_tuser);
         status_hits[rsp_tuser]++;
         if (awaited_reports.size() == 0) begin
            note_mismatch("report with none awaited", '0, got);
         end else begin
            want = awaited_reports.pop_front();
            if (got.filtered !== want.filtered || got.lowest !== want.lowest ||
                got.highest !== want.highest || got.status !== want.status)
               note_mismatch("report mismatch", want, got);
         end
         rx_wait = rx_calm ? 0 : $urandom_range(0, IDLE_MAX);
         if ($urandom_range(0, 31) == 0) rx_calm = ~rx_calm;
         rsp_tready <= (rx_wait == 0);
      end else if (!rsp_tready) begin
         if (rx_wait != 0) rx_wait--;
         rsp_tready <= (rx_wait == 0);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wen)
         idle_run = 0;
      else
         idle_run++;
      if (idle_run >= STALL_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles, %0d reports outstanding",
                  idle_run, awaited_reports.size());
         $display("FAILED: results differ");
         $finish;
      end
   end

   initial begin
      reset_tracker();
      build_directed();
      while (events_planned < EVENT_TARGET) build_phase();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      while (pending_stamps.size() != 0 || awaited_reports.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      leftovers = awaited_reports.size();
      if (leftovers != 0) $display("%0d reports never arrived", leftovers);
      $display("Run covered %0d register writes and %0d skew updates, %0d settling events,",
               writes_done, status_hits[ST_UPDATED], status_hits[ST_SETTLE]);
      $display("  %0d first, %0d read errors, %0d zero divisors, %0d while off; %0d mismatches",
               status_hits[ST_FIRST], status_hits[ST_RDERR], status_hits[ST_ZDIV],
               status_hits[ST_OFF], mismatches);
      if (mismatches == 0 && leftovers == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
